// ----- sv/bsdb_pkg.sv -----
// Shared types and constants for the de Boor B-spline evaluator.
package bsdb_pkg;

    localparam logic [1:0] CMD_KNOT = 2'd0;
    localparam logic [1:0] CMD_CTRL = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;

    localparam logic [1:0] CFG_DEGREE    = 2'd0;
    localparam logic [1:0] CFG_DIMENSION = 2'd1;
    localparam logic [1:0] CFG_CTRL_CNT  = 2'd2;
    localparam logic [1:0] CFG_TOLERANCE = 2'd3;

    // Blend factor limit, raw value 2^30 (2^14 in Q16.16)
    localparam logic [30:0] A_LIMIT = 31'h4000_0000;

    typedef enum logic [2:0] {
        ST_BLENDED,
        ST_END_POINT,
        ST_BREAK_POINT,
        ST_UNDEFINED,
        ST_MULT_HIGH,
        ST_BAD_CONFIG
    } status_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_CTRL,
        SRC_WORK
    } out_src_t;

    typedef struct packed {
        logic [2:0]  degree;
        logic [2:0]  dimension;
        logic [6:0]  ctrl_count;
        logic [15:0] equal_tolerance;
    } cfg_t;

    typedef struct packed {
        logic       take;
        logic       div_start;
        logic       copy_wr;
        logic       blend_mul;
        logic       blend_wr;
        logic       out_load;
        out_src_t   out_src;
        status_t    status;
        logic [1:0] coord_index;
        logic       last;
        logic [6:0] knot_span;
        logic [6:0] multiplicity;
    } dp_cmd_t;

    typedef struct packed {
        logic knot_eq;
        logic knot_lt;
        logic div_busy;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- sv/bspline_de_boor_evaluator.sv -----
// Top level of the de Boor B-spline evaluator: configuration registers and block wiring.
// Writes of knots and control coordinates are accepted only while idle.
// A blended evaluation runs the knot search (one knot a cycle), the decision, the copy
// of h+1 control points, the blend steps, each waiting on the one-bit-a-cycle divider,
// and the output; h = degree - mult.
// One evaluation is in flight at a time; the next request is taken once the last result is queued.
// aresetn is synchronous, active low; it loads the register defaults and empties the result stage.
module bspline_de_boor_evaluator
    import bsdb_pkg::*;
#(
    parameter int MAX_DEGREE = 7,
    parameter int MAX_CTRL   = 64,
    parameter int MAX_DIM    = 4
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // index[6:0], value[38:7], zero[39]
    input  logic [3:0]  s_tuser,   // cmd[1:0], coord_select[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // coord_value[31:0], knot_span[38:32], multiplicity[45:39]
    output logic [4:0]  m_tuser,   // status[2:0], coord_index[4:3]
    output logic        m_tlast
);

    localparam int KNOT_DEPTH = MAX_CTRL + MAX_DEGREE + 1;
    localparam int KAW = $clog2(KNOT_DEPTH);
    localparam int CAW = $clog2(MAX_CTRL * MAX_DIM);
    localparam int WAW = $clog2((MAX_DEGREE + 1) * MAX_DIM);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [KAW-1:0] knot_addr_a, knot_addr_b;
    logic [CAW-1:0] ctrl_addr;
    logic [WAW-1:0] work_addr_a, work_addr_b, work_waddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.degree          <= 3'd3;
            cfg_reg.dimension       <= 3'd2;
            cfg_reg.ctrl_count      <= 7'd4;
            cfg_reg.equal_tolerance <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEGREE:    cfg_reg.degree          <= cfg_wdata[2:0];
                CFG_DIMENSION: cfg_reg.dimension       <= cfg_wdata[2:0];
                CFG_CTRL_CNT:  cfg_reg.ctrl_count      <= cfg_wdata[6:0];
                CFG_TOLERANCE: cfg_reg.equal_tolerance <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bsdb_ctrl #(
        .MAX_DEGREE (MAX_DEGREE),
        .MAX_CTRL   (MAX_CTRL),
        .MAX_DIM    (MAX_DIM)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_cmd      (s_tuser[1:0]),
        .cfg         (cfg_reg),
        .stat        (stat),
        .cmd         (cmd),
        .knot_addr_a (knot_addr_a),
        .knot_addr_b (knot_addr_b),
        .ctrl_addr   (ctrl_addr),
        .work_addr_a (work_addr_a),
        .work_addr_b (work_addr_b),
        .work_waddr  (work_waddr)
    );

    bsdb_dp #(
        .MAX_DEGREE (MAX_DEGREE),
        .MAX_CTRL   (MAX_CTRL),
        .MAX_DIM    (MAX_DIM)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_cmd      (s_tuser[1:0]),
        .in_index    (s_tdata[6:0]),
        .in_sel      (s_tuser[3:2]),
        .in_value    (s_tdata[38:7]),
        .tolerance   (cfg_reg.equal_tolerance),
        .cmd         (cmd),
        .knot_addr_a (knot_addr_a),
        .knot_addr_b (knot_addr_b),
        .ctrl_addr   (ctrl_addr),
        .work_addr_a (work_addr_a),
        .work_addr_b (work_addr_b),
        .work_waddr  (work_waddr),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- sv/bsdb_div.sv -----
// Signed Q16.16 divider for the blend factor, one quotient bit per cycle.
module bsdb_div
    import bsdb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic signed [32:0] den,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quo
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [32:0]        rem_reg, rem_next;
    logic [30:0]        low_reg, low_next;
    logic [30:0]        q_reg, q_next;
    logic [32:0]        dmag_reg, dmag_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] quo_reg, quo_next;

    logic [32:0] nmag, dmag;
    logic [33:0] trial;
    logic        qbit;
    logic [30:0] q_step, mag;

    always_comb begin
        nmag   = num[32] ? 33'(-num) : 33'(num);
        dmag   = den[32] ? 33'(-den) : 33'(den);
        trial  = {rem_reg, low_reg[30]};
        qbit   = trial >= {1'b0, dmag_reg};
        q_step = {q_reg[29:0], qbit};
        mag    = (q_step > A_LIMIT) ? A_LIMIT : q_step;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;

        if (start) begin
            neg_next  = num[32] ^ den[32];
            dmag_next = dmag;
            busy_next = 1'b0;
            if (den == 33'sd0) begin
                quo_next  = '0;
                done_next = 1'b1;
            end else if ({15'b0, nmag} >= {dmag, 15'b0}) begin
                // quotient would reach 2^31: clamp straight away
                quo_next  = (num[32] ^ den[32]) ? 32'd0 - {1'b0, A_LIMIT} : {1'b0, A_LIMIT};
                done_next = 1'b1;
            end else begin
                rem_next  = {15'b0, nmag[32:15]};
                low_next  = {nmag[14:0], 16'b0};
                q_next    = '0;
                cnt_next  = 5'd30;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = qbit ? 33'(trial - {1'b0, dmag_reg}) : trial[32:0];
            low_next = {low_reg[29:0], 1'b0};
            q_next   = q_step;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = neg_reg ? 32'd0 - {1'b0, mag} : {1'b0, mag};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (quo_reg <= 32'sh4000_0000 && quo_reg >= -32'sh4000_0000))
        else $error("blend factor outside clamp range");

endmodule

// ----- sv/bsdb_dp.sv -----
// Datapath: knot, control point and work memories, search compare, blend and result register.
module bsdb_dp
    import bsdb_pkg::*;
#(
    parameter int MAX_DEGREE = 7,
    parameter int MAX_CTRL   = 64,
    parameter int MAX_DIM    = 4,
    localparam int KNOT_DEPTH = MAX_CTRL + MAX_DEGREE + 1,
    localparam int CTRL_DEPTH = MAX_CTRL * MAX_DIM,
    localparam int WORK_DEPTH = (MAX_DEGREE + 1) * MAX_DIM,
    localparam int KAW = $clog2(KNOT_DEPTH),
    localparam int CAW = $clog2(CTRL_DEPTH),
    localparam int WAW = $clog2(WORK_DEPTH)
)(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         in_cmd,
    input  logic [6:0]         in_index,
    input  logic [1:0]         in_sel,
    input  logic signed [31:0] in_value,
    input  logic [15:0]        tolerance,
    input  dp_cmd_t            cmd,
    input  logic [KAW-1:0]     knot_addr_a,
    input  logic [KAW-1:0]     knot_addr_b,
    input  logic [CAW-1:0]     ctrl_addr,
    input  logic [WAW-1:0]     work_addr_a,
    input  logic [WAW-1:0]     work_addr_b,
    input  logic [WAW-1:0]     work_waddr,
    output dp_stat_t           stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic [4:0]         m_tuser,
    output logic               m_tlast
);

    logic signed [31:0] knot_mem [KNOT_DEPTH];
    logic signed [31:0] ctrl_mem [CTRL_DEPTH];
    logic signed [31:0] work_mem [WORK_DEPTH];

    logic signed [31:0] knot_a_reg, knot_b_reg, ctrl_rd_reg, work_a_reg, work_b_reg;
    logic signed [31:0] u_reg;
    logic signed [64:0] prod_reg, prod_next;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [1:0]         out_ci_reg;
    logic signed [31:0] out_value_reg;
    logic [6:0]         out_span_reg, out_mult_reg;
    logic               out_last_reg;

    logic               knot_we, ctrl_we;
    logic [CAW-1:0]     ctrl_waddr;
    logic signed [33:0] kdiff, kabs;
    logic signed [32:0] div_num, div_den, bdiff;
    logic signed [64:0] rnd;
    logic signed [65:0] bsum;
    logic signed [31:0] bsat, out_value_next, quo;
    logic               div_busy, div_done;

    always_comb begin
        knot_we    = cmd.take && in_cmd == CMD_KNOT && 32'(in_index) < KNOT_DEPTH;
        ctrl_we    = cmd.take && in_cmd == CMD_CTRL && 32'(in_index) < MAX_CTRL &&
                     32'(in_sel) < MAX_DIM;
        ctrl_waddr = CAW'(32'(in_index) * MAX_DIM + 32'(in_sel));

        kdiff = 34'(u_reg) - 34'(knot_a_reg);
        kabs  = kdiff[33] ? -kdiff : kdiff;

        div_num = 33'(u_reg) - 33'(knot_a_reg);
        div_den = 33'(knot_b_reg) - 33'(knot_a_reg);

        bdiff     = 33'(work_b_reg) - 33'(work_a_reg);
        prod_next = 65'(bdiff) * 65'(quo);
        // round half up, then drop the fraction
        rnd  = (prod_reg + 65'sd32768) >>> 16;
        bsum = 66'(work_a_reg) + 66'(rnd);
        if (bsum > 66'sd2147483647) begin
            bsat = 32'sh7FFF_FFFF;
        end else if (bsum < -66'sd2147483648) begin
            bsat = 32'sh8000_0000;
        end else begin
            bsat = 32'(bsum);
        end

        case (cmd.out_src)
            SRC_CTRL: out_value_next = ctrl_rd_reg;
            SRC_WORK: out_value_next = work_a_reg;
            default:  out_value_next = '0;
        endcase

        stat.knot_eq  = kabs < 34'(tolerance);
        stat.knot_lt  = u_reg < knot_a_reg;
        stat.div_busy = div_busy;
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || m_tready;
    end

    bsdb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (quo)
    );

    always_ff @(posedge aclk) begin
        if (knot_we) begin
            knot_mem[KAW'(in_index)] <= in_value;
        end
        knot_a_reg <= knot_mem[knot_addr_a];
        knot_b_reg <= knot_mem[knot_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (ctrl_we) begin
            ctrl_mem[ctrl_waddr] <= in_value;
        end
        ctrl_rd_reg <= ctrl_mem[ctrl_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.copy_wr) begin
            work_mem[work_waddr] <= ctrl_rd_reg;
        end else if (cmd.blend_wr) begin
            work_mem[work_waddr] <= bsat;
        end
        work_a_reg <= work_mem[work_addr_a];
        work_b_reg <= work_mem[work_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && in_cmd == CMD_EVAL) begin
            u_reg <= in_value;
        end
        if (cmd.blend_mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.status;
            out_ci_reg     <= cmd.coord_index;
            out_value_reg  <= out_value_next;
            out_span_reg   <= cmd.knot_span;
            out_mult_reg   <= cmd.multiplicity;
            out_last_reg   <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_mult_reg, out_span_reg, out_value_reg};
    assign m_tuser  = {out_ci_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/bsdb_ctrl.sv -----
// Controller: request decode, knot search, case selection and blend sequencing.
module bsdb_ctrl
    import bsdb_pkg::*;
#(
    parameter int MAX_DEGREE = 7,
    parameter int MAX_CTRL   = 64,
    parameter int MAX_DIM    = 4,
    localparam int KNOT_DEPTH = MAX_CTRL + MAX_DEGREE + 1,
    localparam int CTRL_DEPTH = MAX_CTRL * MAX_DIM,
    localparam int WORK_DEPTH = (MAX_DEGREE + 1) * MAX_DIM,
    localparam int KAW = $clog2(KNOT_DEPTH),
    localparam int CAW = $clog2(CTRL_DEPTH),
    localparam int WAW = $clog2(WORK_DEPTH),
    localparam int KW  = $clog2(KNOT_DEPTH + 1),
    localparam int IW  = KW + 2,
    localparam int HW  = $clog2(MAX_DEGREE + 1)
)(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     in_cmd,
    input  cfg_t           cfg,
    input  dp_stat_t       stat,
    output dp_cmd_t        cmd,
    output logic [KAW-1:0] knot_addr_a,
    output logic [KAW-1:0] knot_addr_b,
    output logic [CAW-1:0] ctrl_addr,
    output logic [WAW-1:0] work_addr_a,
    output logic [WAW-1:0] work_addr_b,
    output logic [WAW-1:0] work_waddr
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_DECIDE, S_ONE,
        S_PT_RD, S_PT_WR, S_CP_RD, S_CP_WR,
        S_BL_KN, S_BL_DS, S_BL_DW, S_BL_RD,
        S_BL_MUL, S_BL_WR, S_OUT_RD, S_OUT_WR
    } state_t;

    state_t                state_reg, state_next;
    logic signed [IW-1:0]  kc_reg, kc_next;
    logic [KW-1:0]         s_reg, s_next;
    logic signed [IW-1:0]  fst_reg, fst_next, lst_reg, lst_next;
    logic signed [IW-1:0]  pt_reg, pt_next, i_reg, i_next;
    logic [HW-1:0]         h_reg, h_next, r_reg, r_next, j_reg, j_next;
    logic [2:0]            c_reg, c_next;
    status_t               status_reg, status_next;

    logic signed [IW-1:0]  deg_s, n_s, nk_s, s_s, order_s, f_s, l_s, jb;
    logic                  bad_cfg, take, c_last;

    always_comb begin
        deg_s   = IW'(cfg.degree);
        n_s     = IW'(cfg.ctrl_count);
        nk_s    = n_s + deg_s + IW'(1);
        s_s     = IW'(s_reg);
        order_s = deg_s + IW'(1);
        jb      = i_reg - fst_reg;
        c_last  = c_reg == cfg.dimension - 3'd1;
        take    = s_tvalid && state_reg == S_IDLE;
        bad_cfg = cfg.dimension == 3'd0 || 32'(cfg.dimension) > MAX_DIM ||
                  cfg.ctrl_count == 7'd0 || 32'(cfg.ctrl_count) > MAX_CTRL ||
                  32'(cfg.degree) > MAX_DEGREE || {4'b0, cfg.degree} >= cfg.ctrl_count;
        f_s = '0;
        l_s = '0;

        state_next  = state_reg;
        kc_next     = kc_reg;
        s_next      = s_reg;
        fst_next    = fst_reg;
        lst_next    = lst_reg;
        pt_next     = pt_reg;
        i_next      = i_reg;
        h_next      = h_reg;
        r_next      = r_reg;
        j_next      = j_reg;
        c_next      = c_reg;
        status_next = status_reg;

        cmd              = '0;
        cmd.take         = take;
        cmd.out_src      = SRC_ZERO;
        cmd.status       = status_reg;
        cmd.coord_index  = 2'(c_reg);
        cmd.last         = c_last;
        cmd.knot_span    = kc_reg[IW-1] ? 7'd0 : 7'(kc_reg);
        cmd.multiplicity = 7'(s_reg);

        case (state_reg)
            S_IDLE: begin
                if (take && in_cmd == CMD_EVAL) begin
                    kc_next = '0;
                    s_next  = '0;
                    if (bad_cfg) begin
                        status_next = ST_BAD_CONFIG;
                        state_next  = S_ONE;
                    end else begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (stat.knot_eq) begin
                    s_next = s_reg + KW'(1);
                end
                if (!stat.knot_eq && stat.knot_lt) begin
                    kc_next    = kc_reg - IW'(1);
                    state_next = S_DECIDE;
                end else if (kc_reg == nk_s - IW'(1)) begin
                    state_next = S_DECIDE;
                end else begin
                    kc_next = kc_reg + IW'(1);
                end
            end
            S_DECIDE: begin
                c_next = '0;
                j_next = '0;
                if (s_s > order_s) begin
                    status_next = ST_MULT_HIGH;
                    state_next  = S_ONE;
                end else if (s_s == order_s) begin
                    f_s        = kc_reg - s_s;
                    state_next = S_PT_RD;
                    if (f_s < 0) begin
                        pt_next     = '0;
                        status_next = ST_END_POINT;
                    end else if (f_s + IW'(1) >= n_s) begin
                        pt_next     = f_s;
                        status_next = ST_END_POINT;
                    end else begin
                        pt_next     = f_s + IW'(1);
                        status_next = ST_BREAK_POINT;
                    end
                end else begin
                    f_s = kc_reg - deg_s;
                    l_s = kc_reg - s_s;
                    if (f_s < 0 || l_s >= n_s) begin
                        status_next = ST_UNDEFINED;
                        state_next  = S_ONE;
                    end else begin
                        status_next = ST_BLENDED;
                        fst_next    = f_s;
                        lst_next    = l_s;
                        h_next      = HW'(deg_s - s_s);
                        state_next  = S_CP_RD;
                    end
                end
            end
            S_ONE: begin
                cmd.coord_index = '0;
                cmd.last        = 1'b1;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PT_RD: state_next = S_PT_WR;
            S_PT_WR: begin
                cmd.out_src = SRC_CTRL;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    c_next       = c_reg + 3'd1;
                    state_next   = c_last ? S_IDLE : S_PT_RD;
                end
            end
            S_CP_RD: state_next = S_CP_WR;
            S_CP_WR: begin
                cmd.copy_wr = 1'b1;
                state_next  = S_CP_RD;
                c_next      = c_reg + 3'd1;
                if (c_last) begin
                    c_next = '0;
                    j_next = j_reg + HW'(1);
                    if (j_reg == h_reg) begin
                        r_next     = HW'(1);
                        i_next     = lst_reg;
                        state_next = (h_reg == '0) ? S_OUT_RD : S_BL_KN;
                    end
                end
            end
            S_BL_KN: state_next = S_BL_DS;
            S_BL_DS: begin
                cmd.div_start = 1'b1;
                state_next    = S_BL_DW;
            end
            S_BL_DW: begin
                if (stat.div_done) begin
                    c_next     = '0;
                    state_next = S_BL_RD;
                end
            end
            S_BL_RD:  state_next = S_BL_MUL;
            S_BL_MUL: begin
                cmd.blend_mul = 1'b1;
                state_next    = S_BL_WR;
            end
            S_BL_WR: begin
                cmd.blend_wr = 1'b1;
                c_next       = c_reg + 3'd1;
                state_next   = S_BL_RD;
                if (c_last) begin
                    c_next     = '0;
                    i_next     = i_reg - IW'(1);
                    state_next = S_BL_KN;
                    // step to the next level of the triangle
                    if (i_reg - IW'(1) < fst_reg + IW'(r_reg)) begin
                        i_next = lst_reg;
                        r_next = r_reg + HW'(1);
                        if (r_reg == h_reg) begin
                            state_next = S_OUT_RD;
                        end
                    end
                end
            end
            S_OUT_RD: state_next = S_OUT_WR;
            S_OUT_WR: begin
                cmd.out_src = SRC_WORK;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    c_next       = c_reg + 3'd1;
                    state_next   = c_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase

        knot_addr_a = (state_reg == S_IDLE) ? '0 :
                      (state_reg == S_SRCH) ? KAW'(kc_reg + IW'(1)) : KAW'(i_reg);
        knot_addr_b = KAW'(i_reg + deg_s - IW'(r_reg) + IW'(1));
        if (state_reg == S_PT_RD || state_reg == S_PT_WR) begin
            ctrl_addr = CAW'(32'(pt_reg) * MAX_DIM + 32'(c_reg));
        end else begin
            ctrl_addr = CAW'((32'(fst_reg) + 32'(j_reg)) * MAX_DIM + 32'(c_reg));
        end
        if (state_reg == S_OUT_RD || state_reg == S_OUT_WR) begin
            work_addr_a = WAW'(32'(h_reg) * MAX_DIM + 32'(c_reg));
        end else begin
            work_addr_a = WAW'((32'(jb) - 1) * MAX_DIM + 32'(c_reg));
        end
        work_addr_b = WAW'(32'(jb) * MAX_DIM + 32'(c_reg));
        work_waddr  = (state_reg == S_CP_WR) ? WAW'(32'(j_reg) * MAX_DIM + 32'(c_reg))
                                             : work_addr_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            kc_reg     <= '0;
            s_reg      <= '0;
            fst_reg    <= '0;
            lst_reg    <= '0;
            pt_reg     <= '0;
            i_reg      <= '0;
            h_reg      <= '0;
            r_reg      <= '0;
            j_reg      <= '0;
            c_reg      <= '0;
            status_reg <= ST_BLENDED;
        end else begin
            state_reg  <= state_next;
            kc_reg     <= kc_next;
            s_reg      <= s_next;
            fst_reg    <= fst_next;
            lst_reg    <= lst_next;
            pt_reg     <= pt_next;
            i_reg      <= i_next;
            h_reg      <= h_next;
            r_reg      <= r_next;
            j_reg      <= j_next;
            c_reg      <= c_next;
            status_reg <= status_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an unsent result");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

    a_mult_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DECIDE |-> s_s <= kc_reg + IW'(1))
        else $error("multiplicity exceeds knots searched");

endmodule
